@@ rtl/aes_stu_pkg.sv @@
// aes state transform unit package: command codes, sbox tables, gf helpers
// used by the column lane and the top level; no dependencies
`timescale 1ns / 1ps

package aes_stu_pkg;

    typedef enum logic [2:0] {
        CMD_SUB_BYTES     = 3'd0,
        CMD_SHIFT_ROWS    = 3'd1,
        CMD_MIX_COLUMNS   = 3'd2,
        CMD_INV_SUB_BYTES = 3'd3,
        CMD_INV_SHIFT     = 3'd4,
        CMD_INV_MIX       = 3'd5
    } cmd_t;

    typedef logic [7:0] byte_t;
    typedef logic [31:0] col_t;

    localparam int NUM_LANES = 4;

    localparam logic [2047:0] FWD_SBOX = {
        128'h16bb54b00f2d99416842e6bf0d89a18c,
        128'hdf2855cee9871e9b948ed9691198f8e1,
        128'h9e1dc186b95735610ef6034866b53e70,
        128'h8a8bbd4b1f74dde8c6b4a61c2e2578ba,
        128'h08ae7a65eaf4566ca94ed58d6d37c8e7,
        128'h79e4959162acd3c25c2406490a3a32e0,
        128'hdb0b5ede14b8ee4688902a22dc4f8160,
        128'h73195d643d7ea7c41744975fec130ccd,
        128'hd2f3ff1021dab6bcf5389d928f40a351,
        128'ha89f3c507f02f94585334d43fbaaefd0,
        128'hcf584c4a39becb6a5bb1fc20ed00d153,
        128'h842fe329b3d63b52a05a6e1b1a2c8309,
        128'h75b227ebe28012079a059618c323c704,
        128'h1531d871f1e5a534ccf73f362693fdb7,
        128'hc072a49cafa2d4adf04759fa7dc982ca,
        128'h76abd7fe2b670130c56f6bf27b777c63
    };

    function automatic byte_t sbox(input byte_t b);
        return FWD_SBOX[{b, 3'b000} +: 8];
    endfunction

    // inverse table built at elaboration from the forward table
    function automatic logic [2047:0] build_inv();
        logic [2047:0] t;
        byte_t v;
        t = '0;
        for (int i = 0; i < 256; i++) begin
            v = FWD_SBOX[i*8 +: 8];
            t[{v, 3'b000} +: 8] = byte_t'(i);
        end
        return t;
    endfunction

    localparam logic [2047:0] INV_SBOX = build_inv();

    function automatic byte_t inv_sbox(input byte_t b);
        return INV_SBOX[{b, 3'b000} +: 8];
    endfunction

    function automatic byte_t xt(input byte_t x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

endpackage

@@ rtl/aes_stu_lane.sv @@
// one column lane: sub bytes, inverse sub bytes and (inverse) mix columns
// on a 32-bit column already routed by shift rows; uses aes_stu_pkg
`timescale 1ns / 1ps

module aes_stu_lane (
    input  aes_stu_pkg::cmd_t cmd,
    input  aes_stu_pkg::col_t col_in,   // row 0 in bits 31:24
    output aes_stu_pkg::col_t col_out
);
    import aes_stu_pkg::*;

    byte_t a [4];
    byte_t d2 [4];
    byte_t d4 [4];
    byte_t d8 [4];
    byte_t fm [4];
    byte_t im [4];
    byte_t sb [4];
    byte_t isb [4];

    // per-byte tables and field multiples
    always_comb begin
        for (int r = 0; r < 4; r++) begin
            a[r]   = col_in[31-8*r -: 8];
            sb[r]  = sbox(a[r]);
            isb[r] = inv_sbox(a[r]);
            d2[r]  = xt(a[r]);
            d4[r]  = xt(d2[r]);
            d8[r]  = xt(d4[r]);
        end
        // forward: 2,3,1,1; inverse: 14,11,13,9 rotated per row
        for (int r = 0; r < 4; r++) begin
            fm[r] = d2[r] ^ (d2[(r+1)%4] ^ a[(r+1)%4]) ^ a[(r+2)%4] ^ a[(r+3)%4];
            im[r] = (d8[r] ^ d4[r] ^ d2[r])
                  ^ (d8[(r+1)%4] ^ d2[(r+1)%4] ^ a[(r+1)%4])
                  ^ (d8[(r+2)%4] ^ d4[(r+2)%4] ^ a[(r+2)%4])
                  ^ (d8[(r+3)%4] ^ a[(r+3)%4]);
        end
    end

    // select by command
    always_comb begin
        for (int r = 0; r < 4; r++) begin
            unique case (cmd)
                CMD_SUB_BYTES:     col_out[31-8*r -: 8] = sb[r];
                CMD_MIX_COLUMNS:   col_out[31-8*r -: 8] = fm[r];
                CMD_INV_SUB_BYTES: col_out[31-8*r -: 8] = isb[r];
                CMD_INV_MIX:       col_out[31-8*r -: 8] = im[r];
                default:           col_out[31-8*r -: 8] = a[r];
            endcase
        end
    end

endmodule

@@ rtl/aes_state_transform_unit_top.sv @@
// aes state transform unit top: row routing, four column lanes, merge and
// output register with skid stage; uses aes_stu_pkg and aes_stu_lane
//
// channel  dir  payload
// s_axis   in   tdata = command[2:0], state_high[66:3], state_low[130:67]
// m_axis   out  tdata = result_high[63:0], result_low[127:64]
//
// one item per cycle while s_tready is high; result registered in out_reg
// a two-entry output buffer (out_reg, skid_reg) absorbs one item under stalls
// aresetn clears only the valid flags
`timescale 1ns / 1ps

module aes_state_transform_unit_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [135:0] s_tdata,   // command, state_high, state_low
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata    // result_high, result_low
);
    import aes_stu_pkg::*;

    cmd_t cmd;
    logic [63:0] hi, lo;
    byte_t m [16];
    col_t lane_in [NUM_LANES];
    col_t lane_out [NUM_LANES];
    logic [127:0] res;
    logic [127:0] out_reg, skid_reg;
    logic out_v_reg, skid_v_reg;
    logic out_v_next, skid_v_next;
    logic acc;

    assign cmd = cmd_t'(s_tdata[2:0]);
    assign hi = s_tdata[66:3];
    assign lo = s_tdata[130:67];

    // unpack and shift rows routing into lane columns
    always_comb begin
        for (int k = 0; k < 16; k++)
            m[k] = (k < 8) ? hi[63-8*(k%8) -: 8] : lo[63-8*(k%8) -: 8];
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++) begin
                if (cmd == CMD_SHIFT_ROWS)
                    lane_in[c][31-8*r -: 8] = m[((c+r)%4)*4 + r];
                else if (cmd == CMD_INV_SHIFT)
                    lane_in[c][31-8*r -: 8] = m[((c+4-r)%4)*4 + r];
                else
                    lane_in[c][31-8*r -: 8] = m[c*4 + r];
            end
    end

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        aes_stu_lane u_lane (.cmd(cmd), .col_in(lane_in[g]), .col_out(lane_out[g]));
    end

    // merge lanes into the output layout
    assign res = {lane_out[0], lane_out[1], lane_out[2], lane_out[3]};

    assign s_tready = ~skid_v_reg;
    assign acc = s_tvalid & s_tready;
    assign m_tvalid = out_v_reg;
    assign m_tdata = {out_reg[63:0], out_reg[127:64]};

    // output register plus skid entry
    always_comb begin
        out_v_next  = out_v_reg;
        skid_v_next = skid_v_reg;
        if (!out_v_reg || m_tready) begin
            out_v_next  = skid_v_reg | acc;
            skid_v_next = 1'b0;
        end else if (acc) begin
            skid_v_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_v_reg || m_tready) begin
            out_reg <= skid_v_reg ? skid_reg : res;
        end
        if (acc && !(skid_v_reg == 1'b0 && (!out_v_reg || m_tready)))
            skid_reg <= res;
        if (!aresetn) begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end else begin
            out_v_reg  <= out_v_next;
            skid_v_reg <= skid_v_next;
        end
    end

    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_v_reg |-> out_v_reg) else $error("skid holds item without output");
    a_hold_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(out_reg)) else $error("output changed");
    a_acc_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        acc |=> out_v_reg) else $error("accepted item lost");

endmodule

@@ tb/aes_state_transform_unit_top_test.sv @@
// testbench for the aes state transform unit: predicts each transformed state
// and checks the result stream; depends on aes_stu_pkg and the top level rtl
`timescale 1ns / 1ps

module aes_state_transform_unit_top_test;
    import aes_stu_pkg::*;

    // transformed-state predictor and queue of pending results
    class aes_state_scoreboard;
        logic [63:0] want_high[$];
        logic [63:0] want_low[$];
        int errors;
        byte_t fwd_tab[256];
        byte_t inv_tab[256];

        function new();
            logic [7:0] e [256] = '{
                8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,
                8'hfe,8'hd7,8'hab,8'h76,8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,
                8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,8'hb7,8'hfd,8'h93,8'h26,
                8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
                8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,
                8'heb,8'h27,8'hb2,8'h75,8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,
                8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,8'h53,8'hd1,8'h00,8'hed,
                8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
                8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,
                8'h50,8'h3c,8'h9f,8'ha8,8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,
                8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,8'hcd,8'h0c,8'h13,8'hec,
                8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
                8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,
                8'hde,8'h5e,8'h0b,8'hdb,8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,
                8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,8'he7,8'hc8,8'h37,8'h6d,
                8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
                8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,
                8'h4b,8'hbd,8'h8b,8'h8a,8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,
                8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,8'he1,8'hf8,8'h98,8'h11,
                8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
                8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,
                8'hb0,8'h54,8'hbb,8'h16};
            for (int i = 0; i < 256; i++) begin
                fwd_tab[i] = e[i];
                inv_tab[e[i]] = byte_t'(i);
            end
            errors = 0;
        endfunction

        // multiply by a small constant in gf(2^8)
        function byte_t gmul(byte_t a, int k);
            byte_t acc;
            byte_t p;
            acc = '0;
            p = a;
            while (k != 0) begin
                if (k & 1) acc ^= p;
                p = {p[6:0], 1'b0} ^ (p[7] ? 8'h1b : 8'h00);
                k = k >> 1;
            end
            return acc;
        endfunction

        function void note_item(logic [2:0] op, logic [63:0] hi, logic [63:0] lo);
            byte_t s[4][4];
            byte_t t[4][4];
            int coef[4];
            logic [63:0] w;
            for (int k = 0; k < 16; k++) begin
                w = (k < 8) ? hi : lo;
                s[k % 4][k / 4] = w[56 - 8 * (k % 8) +: 8];
            end
            t = s;
            if (op == CMD_MIX_COLUMNS)
                coef = '{2, 3, 1, 1};
            else
                coef = '{14, 11, 13, 9};
            for (int r = 0; r < 4; r++)
                for (int c = 0; c < 4; c++) begin
                    case (op)
                        CMD_SUB_BYTES: t[r][c] = fwd_tab[s[r][c]];
                        CMD_SHIFT_ROWS: t[r][c] = s[r][(c + r) % 4];
                        CMD_INV_SUB_BYTES: t[r][c] = inv_tab[s[r][c]];
                        CMD_INV_SHIFT: t[r][c] = s[r][(c + 4 - r) % 4];
                        CMD_MIX_COLUMNS, CMD_INV_MIX: begin
                            t[r][c] = '0;
                            for (int i = 0; i < 4; i++)
                                t[r][c] ^= gmul(s[i][c], coef[(i + 4 - r) % 4]);
                        end
                        default: ;
                    endcase
                end
            hi = '0;
            lo = '0;
            for (int k = 0; k < 16; k++)
                if (k < 8) hi[56 - 8 * k +: 8] = t[k % 4][k / 4];
                else lo[56 - 8 * (k - 8) +: 8] = t[k % 4][k / 4];
            want_high.push_back(hi);
            want_low.push_back(lo);
        endfunction

        function void check_result(logic [127:0] d);
            logic [63:0] eh;
            logic [63:0] el;
            if (want_high.size() == 0) begin
                $error("unexpected result %h", d);
                errors++;
                return;
            end
            eh = want_high.pop_front();
            el = want_low.pop_front();
            if (d[63:0] !== eh) begin
                $error("result_high expected %h actual %h", eh, d[63:0]);
                errors++;
            end
            if (d[127:64] !== el) begin
                $error("result_low expected %h actual %h", el, d[127:64]);
                errors++;
            end
        endfunction
    endclass

    logic aclk = 0;
    logic aresetn = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [135:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [127:0] m_tdata;

    int send_idle = 29;
    int recv_idle = 47;
    bit hold_recv = 0;
    aes_state_scoreboard board = new();

    always #1 aclk = ~aclk;

    aes_state_transform_unit_top i_dut (.*);

    // send one item, idling at random before it
    task automatic send_state(logic [2:0] op, logic [63:0] hi, logic [63:0] lo);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {5'b00000, lo, hi, op};
        do @(posedge aclk); while (!s_tready);
        board.note_item(op, hi, lo);
    endtask

    task automatic send_random(int n);
        logic [63:0] h;
        logic [63:0] l;
        for (int i = 0; i < n; i++) begin
            h = {$urandom, $urandom};
            l = {$urandom, $urandom};
            send_state(3'($urandom_range(7)), h, l);
        end
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (board.want_high.size() != 0) @(posedge aclk);
    endtask

    // result side: random stalls or a long hold-off
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_result(m_tdata);
        m_tready <= !hold_recv && ($urandom_range(99) >= recv_idle);
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        // directed: every command at field extremes, plus unused codes
        for (int op = 0; op < 8; op++) begin
            send_state(3'(op), '0, '0);
            send_state(3'(op), '1, '1);
        end
        send_state(CMD_MIX_COLUMNS, 64'hdbf201c6_13450a01, 64'hd4d4d4d4_2d26314c);
        send_state(CMD_INV_MIX, 64'h8e9f01c6_4ddc01c6, 64'hd5d5d7d6_4d7ebdf8);
        send_state(CMD_INV_SUB_BYTES, 64'h00010203_04050607, 64'h08090a0b_0c0d0e0f);
        send_random(600);
        drain();
        // receiver holds off while items keep coming
        hold_recv <= 1;
        fork
            send_random(20);
            begin
                repeat (60) @(posedge aclk);
                hold_recv <= 0;
            end
        join
        send_random(100);
        drain();
        send_idle = 47;
        recv_idle = 29;
        send_random(600);
        send_idle = 0;
        recv_idle = 0;
        send_random(560);
        drain();
        repeat (10) @(posedge aclk);
        if (board.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #200000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
